// ===== src/fcps_pkg.sv =====
// Shared types for the FIFO cluster processor scheduler.
// No dependencies; the top level, fcps_regs and fcps_timers import this package.
package fcps_pkg;

    // Widest processor count and task length the block supports.
    localparam int PROCS_W_MAX = 7;
    localparam int TICKS_W_MAX = 16;

    // Configuration register indexes.
    localparam logic REG_QUEUE_CAPACITY    = 1'b0;
    localparam logic REG_ARRIVAL_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [6:0]  queue_capacity;
        logic [16:0] arrival_threshold;
    } t_cfg;

    // Head task offered to the processor array for one tick.
    typedef struct packed {
        logic                   valid;
        logic [PROCS_W_MAX-1:0] procs;
        logic [TICKS_W_MAX-1:0] ticks;
    } t_disp_req;

    // Outcome of one tick in the processor array.
    typedef struct packed {
        logic                   dispatched;
        logic                   idle;
        logic [PROCS_W_MAX-1:0] free_cnt;
        logic [PROCS_W_MAX-1:0] busy_cnt;
    } t_tmr_stat;

endpackage

// ===== src/fifo_cluster_processor_scheduler.sv =====
// FIFO cluster processor scheduler, top level.
// A tick accepted in S_IDLE moves the sequencer to S_EXEC, where the head task is resolved;
// its result beat is then registered onto the outputs and strobed by o_done.
// No new tick is taken while busy, that is while the sequencer is in S_EXEC.
// The receiver cannot stall; each result beat is shown for exactly one cycle.
// Reset (synchronous, active low) empties the queue and idles every processor at once.
module fifo_cluster_processor_scheduler #(
    parameter int NUM_PROCS      = 16,
    parameter int QUEUE_DEPTH    = 64,
    parameter int MAX_TASK_TICKS = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick command channel.
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_random_sample,
    input  logic [4:0]  i_task_procs,
    input  logic [7:0]  i_task_ticks,
    // Result beat.
    output logic        o_done,
    output logic        o_task_arrived,
    output logic        o_task_dropped,
    output logic        o_task_dispatched,
    output logic        o_cluster_idle,
    output logic [4:0]  o_free_procs,
    output logic [6:0]  o_queue_count,
    output logic [31:0] o_created_total,
    output logic [31:0] o_dropped_total,
    output logic [31:0] o_idle_total,
    output logic [39:0] o_busy_sum_total,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fcps_pkg::*;

    // Widths derived from the parameters.
    localparam int PW   = $clog2(NUM_PROCS + 1);
    localparam int TW   = $clog2(MAX_TASK_TICKS + 1);
    localparam int EW   = PW + TW;
    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam logic [39:0] MAX40 = '1;

    // Two-state sequencer: waiting for a tick, or resolving the head task.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state    r_state, n_state;
    t_cfg      w_cfg;
    t_disp_req w_req;
    t_tmr_stat w_stat;

    logic          w_accept;
    logic          w_step;
    logic          w_arrive;
    logic          w_full;
    logic          w_write;
    logic [CMPW-1:0] w_cnt_x;
    logic [CMPW-1:0] w_cap_x;
    logic [PW-1:0] w_procs;
    logic [TW-1:0] w_ticks;
    logic [EW-1:0] w_entry;
    logic [EW-1:0] w_rdata;
    logic [EW-1:0] w_head;
    logic [40:0]   w_busy_add;

    // Queue pointers and fill level.
    logic [AW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;
    // Forwarding of a task that enters an empty queue: the RAM read issued
    // in the same cycle would miss it.
    logic          r_fwd;
    logic [EW-1:0] r_fwd_task;
    // Statistics.
    logic [31:0]   r_created, r_dropped, r_idle_cnt;
    logic [39:0]   r_busy_sum;
    // Result flags held for the beat.
    logic          r_done, r_arrived, r_drop_flag, r_disp, r_idle_flag;
    logic [4:0]    r_free_out;

    fcps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign busy     = (r_state == S_EXEC);
    assign w_accept = start && !busy;
    assign w_step   = (r_state == S_EXEC);

    // Arrival and admission are settled in the accept cycle. A capacity of
    // zero acts as one, and the RAM depth bounds the queue whatever is set.
    always_comb begin
        w_arrive = {1'b0, i_random_sample} < w_cfg.arrival_threshold;
        w_cnt_x  = CMPW'(r_count);
        w_cap_x  = (w_cfg.queue_capacity == '0) ? CMPW'(1) : CMPW'(w_cfg.queue_capacity);
        w_full   = (w_cnt_x >= w_cap_x) || (w_cnt_x >= CMPW'(QUEUE_DEPTH));
        w_write  = w_arrive && !w_full;

        // Clamp the demand to one through NUM_PROCS and the length to one
        // through MAX_TASK_TICKS.
        if (i_task_procs == '0) begin
            w_procs = PW'(1);
        end else if (7'(i_task_procs) > 7'(NUM_PROCS)) begin
            w_procs = PW'(NUM_PROCS);
        end else begin
            w_procs = PW'(i_task_procs);
        end
        if (i_task_ticks == '0) begin
            w_ticks = TW'(1);
        end else if (17'(i_task_ticks) > 17'(MAX_TASK_TICKS)) begin
            w_ticks = TW'(MAX_TASK_TICKS);
        end else begin
            w_ticks = TW'(i_task_ticks);
        end
        w_entry = {w_procs, w_ticks};
    end

    // Task queue storage. The head entry is read at accept; the read and the
    // write only meet on one entry when the queue is empty, which the
    // forwarding path covers.
    fcps_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_write),
        .i_waddr (r_tail),
        .i_wdata (w_entry),
        .i_re    (w_accept),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    assign w_head      = r_fwd ? r_fwd_task : w_rdata;
    assign w_req.valid = w_step && (r_count != '0);
    assign w_req.procs = PROCS_W_MAX'(w_head[EW-1:TW]);
    assign w_req.ticks = TICKS_W_MAX'(w_head[TW-1:0]);

    fcps_timers #(
        .NUM_PROCS (NUM_PROCS),
        .PW        (PW),
        .TW        (TW)
    ) u_timers (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (w_req),
        .o_stat  (w_stat)
    );

    assign w_busy_add = {1'b0, r_busy_sum} + 41'(w_stat.busy_cnt);

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = w_accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_fwd       <= 1'b0;
            r_created   <= '0;
            r_dropped   <= '0;
            r_idle_cnt  <= '0;
            r_busy_sum  <= '0;
            r_done      <= 1'b0;
            r_arrived   <= 1'b0;
            r_drop_flag <= 1'b0;
            r_disp      <= 1'b0;
            r_idle_flag <= 1'b0;
            r_free_out  <= 5'(NUM_PROCS);
        end else begin
            r_state <= n_state;
            r_done  <= w_step;
            if (w_accept) begin
                r_arrived   <= w_arrive;
                r_drop_flag <= w_arrive && w_full;
                r_fwd       <= w_write && (r_count == '0);
                if (w_arrive) begin
                    r_created <= (r_created == '1) ? r_created : r_created + 32'd1;
                end
                if (w_arrive && w_full) begin
                    r_dropped <= (r_dropped == '1) ? r_dropped : r_dropped + 32'd1;
                end
                if (w_write) begin
                    r_tail  <= (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + AW'(1);
                    r_count <= r_count + CW'(1);
                end
            end
            if (w_step) begin
                r_disp      <= w_stat.dispatched;
                r_idle_flag <= w_stat.idle;
                r_free_out  <= 5'(w_stat.free_cnt);
                if (w_stat.dispatched) begin
                    r_head  <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
                    r_count <= r_count - CW'(1);
                end
                if (w_stat.idle) begin
                    r_idle_cnt <= (r_idle_cnt == '1) ? r_idle_cnt : r_idle_cnt + 32'd1;
                end
                r_busy_sum <= (w_busy_add > {1'b0, MAX40}) ? MAX40 : w_busy_add[39:0];
            end
        end
    end

    // The forwarded copy is payload only.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fwd_task <= w_entry;
        end
    end

    // Every statistic and level below is stable from the resolving edge until
    // the next tick is accepted, so the beat can show the registers directly.
    assign o_done            = r_done;
    assign o_task_arrived    = r_arrived;
    assign o_task_dropped    = r_drop_flag;
    assign o_task_dispatched = r_disp;
    assign o_cluster_idle    = r_idle_flag;
    assign o_free_procs      = r_free_out;
    assign o_queue_count     = 7'(r_count);
    assign o_created_total   = r_created;
    assign o_dropped_total   = r_dropped;
    assign o_idle_total      = r_idle_cnt;
    assign o_busy_sum_total  = r_busy_sum;
endmodule

// ===== src/fcps_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module fcps_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/fcps_regs.sv =====
// APB-style configuration registers of the scheduler.
// Depends on fcps_pkg for the configuration struct and register indexes.
module fcps_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output fcps_pkg::t_cfg o_cfg
);
    import fcps_pkg::*;

    logic [6:0]  r_cap;
    logic [16:0] r_thr;
    logic        w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 7'd64;
            r_thr <= 17'd32768;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_QUEUE_CAPACITY:    r_cap <= pwdata[6:0];
                REG_ARRIVAL_THRESHOLD: r_thr <= pwdata[16:0];
                default:               r_cap <= r_cap;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_QUEUE_CAPACITY:    prdata = {25'd0, r_cap};
            REG_ARRIVAL_THRESHOLD: prdata = {15'd0, r_thr};
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.queue_capacity    = r_cap;
    assign o_cfg.arrival_threshold = r_thr;
endmodule

// ===== src/fcps_timers.sv =====
// Processor busy timers with lowest-index allocation and parallel countdown.
// Depends on fcps_pkg for the dispatch request and status structs.
module fcps_timers #(
    parameter int NUM_PROCS = 16,
    parameter int PW        = 5,
    parameter int TW        = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  fcps_pkg::t_disp_req i_req,
    output fcps_pkg::t_tmr_stat o_stat
);
    import fcps_pkg::*;

    localparam logic [NUM_PROCS-1:0] ONE = NUM_PROCS'(1);

    logic [TW-1:0]        r_timer [NUM_PROCS];
    logic [TW-1:0]        n_timer [NUM_PROCS];
    logic [TW-1:0]        w_after [NUM_PROCS];
    logic [PW-1:0]        r_free;
    logic [PW-1:0]        n_free;
    logic [NUM_PROCS-1:0] w_idle;
    logic [NUM_PROCS-1:0] w_take;
    logic [NUM_PROCS-1:0] w_live;
    logic [NUM_PROCS-1:0] w_left;
    logic [PW-1:0]        w_need;
    logic [TW-1:0]        w_ticks;
    logic                 w_go;

    always_comb begin
        logic [NUM_PROCS-1:0] below;
        below   = '0;
        w_need  = PW'(i_req.procs);
        w_ticks = TW'(i_req.ticks);
        w_go    = i_req.valid && (r_free >= w_need);
        for (int i = 0; i < NUM_PROCS; i++) begin
            w_idle[i] = (r_timer[i] == '0);
        end
        // A processor is taken when it is idle and fewer idle processors
        // than the task needs sit below it.
        for (int i = 0; i < NUM_PROCS; i++) begin
            below      = (ONE << i) - ONE;
            w_take[i]  = w_go && w_idle[i] && (PW'($countones(w_idle & below)) < w_need);
            w_after[i] = w_take[i] ? w_ticks : r_timer[i];
            w_live[i]  = (w_after[i] != '0);
            n_timer[i] = w_live[i] ? w_after[i] - TW'(1) : '0;
            w_left[i]  = (n_timer[i] != '0);
        end
        n_free = PW'(NUM_PROCS - $countones(w_left));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PROCS; i++) begin
                r_timer[i] <= '0;
            end
            r_free <= PW'(NUM_PROCS);
        end else if (i_step) begin
            r_timer <= n_timer;
            r_free  <= n_free;
        end
    end

    assign o_stat.dispatched = w_go;
    assign o_stat.idle       = ~|w_live;
    assign o_stat.free_cnt   = PROCS_W_MAX'(n_free);
    assign o_stat.busy_cnt   = PROCS_W_MAX'($countones(w_left));
endmodule

// ===== src/fcps_checker.sv =====
// Port-level checks for the FIFO cluster processor scheduler, bound to the top level.
// Depends on fifo_cluster_processor_scheduler for the bind target.
module fcps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_task_arrived,
    input logic        o_task_dropped,
    input logic        o_task_dispatched,
    input logic        o_cluster_idle
);
    // An accepted tick is resolved in the next cycle and its beat follows.
    a_tick_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy ##1 o_done))
        else $error("accepted tick did not produce its result beat on time");

    // One beat per tick: strobes never come back to back.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // The beat is shown while the block is free to take the next tick.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat shown while busy");

    // A drop needs an arrival.
    a_drop_arrival: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_task_dropped) |-> o_task_arrived)
        else $error("task dropped without an arrival");

    // A dispatched task keeps at least one processor busy over the countdown.
    a_idle_no_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_cluster_idle) |-> !o_task_dispatched)
        else $error("idle tick reported together with a dispatch");
endmodule

bind fifo_cluster_processor_scheduler fcps_checker u_fcps_checker (.*);
